// ===== rtl/core/pwe_pkg.sv =====
package pwe_pkg;

  localparam int unsigned PeriodWidth = 20;
  localparam int unsigned PwWidth     = 12;
  localparam int unsigned LevelWidth  = 6;
  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned QuotWidth   = 6;   // quotient 0..50
  localparam int unsigned RemWidth    = PeriodWidth + 1;

  localparam logic [PeriodWidth-1:0] PeriodReset = 20'd1000;

  typedef enum logic [CmdWidth-1:0] {
    CmdTriangle = 2'd0,
    CmdSawtooth = 2'd1,
    CmdPulse    = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  // Item context carried along the cell row.
  typedef struct packed {
    cmd_e                   cmd;
    logic                   d_gt_p;
    logic                   pulse_hi;
  } ctx_t;

endpackage

// ===== rtl/core/pwe_if.sv =====
interface pwe_in_if #(
  parameter int unsigned TimeWidth = 32
);
  logic                        valid;
  logic                        ready;
  logic [pwe_pkg::CmdWidth-1:0] cmd;
  logic signed [TimeWidth-1:0] time_us;
  logic [pwe_pkg::PwWidth-1:0] pulse_width;

  modport source (output valid, cmd, time_us, pulse_width, input ready);
  modport sink (input valid, cmd, time_us, pulse_width, output ready);
endinterface

interface pwe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwe_pkg::LevelWidth-1:0] level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

// ===== rtl/core/pwe_mod_cell.sv =====
// One restoring step of the time magnitude mod P: subtract P<<Shift when it fits.
module pwe_mod_cell #(
  parameter int unsigned Width = 32,
  parameter int unsigned Shift = 0
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [Width-1:0]                    rem_i,
  input  logic [pwe_pkg::PeriodWidth-1:0]     period_i,
  output logic [Width-1:0]                    rem_o
);
  localparam int unsigned Wide = Width + pwe_pkg::PeriodWidth + 1;
  logic [Wide-1:0] sub;
  logic [Wide-1:0] rem_ext;

  assign sub     = Wide'(period_i) << Shift;
  assign rem_ext = Wide'(rem_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= (rem_ext >= sub) ? Width'(rem_ext - sub) : rem_i;
    end
  end
endmodule

// ===== rtl/core/pwe_div_cell.sv =====
// One step of (num*50)/P: one quotient bit per cell, restoring.
module pwe_div_cell (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [pwe_pkg::RemWidth+5:0]        rem_i,
  input  logic [pwe_pkg::QuotWidth-1:0]       quot_i,
  input  logic [pwe_pkg::PeriodWidth-1:0]     period_i,
  input  logic [2:0]                          bit_i,
  output logic [pwe_pkg::RemWidth+5:0]        rem_o,
  output logic [pwe_pkg::QuotWidth-1:0]       quot_o
);
  localparam int unsigned W = pwe_pkg::RemWidth + 6;
  logic [W+5:0] sub;

  assign sub = (W+6)'(period_i) << bit_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if ((W+6)'(rem_i) >= sub) begin
        rem_o  <= W'((W+6)'(rem_i) - sub);
        quot_o <= quot_i | (pwe_pkg::QuotWidth'(1) << bit_i);
      end else begin
        rem_o  <= rem_i;
        quot_o <= quot_i;
      end
    end
  end
endmodule

// ===== rtl/core/periodic_waveform_evaluator.sv =====
// Stages from input transfer to result valid: magnitude, mod cells, phase, operand, divider cells, output register.
// Throughput: one item per cycle; pipeline stalls as a whole when the output
// register is full and not taken (ready = output stage free or draining).
// Reset: rst_ni asynchronous active low clears all valid bits and sets
// period_us to 1000. Period 0 is used as 1.
module periodic_waveform_evaluator #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pwe_pkg::PeriodWidth-1:0]    cfg_wdata_i,
  pwe_in_if.sink                             in_if,
  pwe_out_if.source                          out_if
);
  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned MS   = TW;          // mod cells, shifts TW-1..0
  localparam int unsigned DS   = pwe_pkg::QuotWidth; // divider cells
  localparam int unsigned RW   = pwe_pkg::RemWidth;
  localparam int unsigned DW   = RW + 6;
  localparam int unsigned NS   = 1 + MS + 2 + DS + 1; // valid stages

  logic [pwe_pkg::PeriodWidth-1:0] period_q;
  logic [pwe_pkg::PeriodWidth-1:0] p_eff;
  logic [NS-1:0] vld_q;
  logic          adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= pwe_pkg::PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end
  assign p_eff = (period_q == '0) ? pwe_pkg::PeriodWidth'(1) : period_q;

  // Whole pipe advances unless the last stage holds an untaken result.
  assign adv         = !(vld_q[NS-1] && !out_if.ready);
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_if.valid};
    end
  end

  // Stage 0: magnitude. Negative t uses -(t+1) = ~t.
  logic [TW-1:0] mag_q [MS+1];
  logic          neg_q [MS+1];
  pwe_pkg::cmd_e cmd_q [MS+2];
  logic [pwe_pkg::PwWidth-1:0] pw_q [MS+2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q[0] <= in_if.time_us[TW-1] ? ~in_if.time_us : in_if.time_us;
      neg_q[0] <= in_if.time_us[TW-1];
      cmd_q[0] <= pwe_pkg::cmd_e'(in_if.cmd);
      pw_q[0]  <= in_if.pulse_width;
    end
  end

  for (genvar i = 0; i < MS; i++) begin : g_mod
    pwe_mod_cell #(.Width(TW), .Shift(MS-1-i)) u_cell (
      .clk_i, .en_i(adv), .rem_i(mag_q[i]), .period_i(p_eff), .rem_o(mag_q[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg_q[i+1] <= neg_q[i];
        cmd_q[i+1] <= cmd_q[i];
        pw_q[i+1]  <= pw_q[i];
      end
    end
  end

  // Phase stage: remainder is below P so fits RW bits.
  logic [RW-1:0] ph_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q <= neg_q[MS] ? RW'(p_eff) - RW'(mag_q[MS]) : RW'(mag_q[MS]);
      cmd_q[MS+1] <= cmd_q[MS];
      pw_q[MS+1]  <= pw_q[MS];
    end
  end

  // Operand stage: numerator for the divider and the pulse compare.
  logic [RW:0]   d2;
  logic [RW:0]   dmod;
  logic signed [47:0] lhs, rhs;
  logic [DW-1:0] num_q [DS+1];
  logic [pwe_pkg::QuotWidth-1:0] quo_q [DS+1];
  pwe_pkg::ctx_t ctx_q [DS+1];

  assign d2   = {ph_q, 1'b0};
  assign dmod = (d2 >= (RW+1)'(p_eff) && d2 < ((RW+1)'(p_eff) << 1)) ?
                d2 - (RW+1)'(p_eff) : ((d2 >= ((RW+1)'(p_eff) << 1)) ?
                d2 - ((RW+1)'(p_eff) << 1) : d2);
  assign lhs  = 48'(ph_q) * 48'sd8190;
  assign rhs  = 48'(p_eff >> 1) * 48'sd8190 +
                $signed(48'(p_eff)) * ($signed({36'd0, pw_q[MS+1]} <<< 1) - 48'sd4095);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[0] <= (cmd_q[MS+1] == pwe_pkg::CmdTriangle) ?
                  DW'(dmod) * DW'(50) : DW'(ph_q) * DW'(50);
      quo_q[0] <= '0;
      ctx_q[0] <= '{cmd: cmd_q[MS+1], d_gt_p: d2 > (RW+1)'(p_eff),
                    pulse_hi: lhs > rhs};
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    pwe_div_cell u_cell (
      .clk_i, .en_i(adv), .rem_i(num_q[j]), .quot_i(quo_q[j]), .period_i(p_eff),
      .bit_i(3'(DS-1-j)), .rem_o(num_q[j+1]), .quot_o(quo_q[j+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) ctx_q[j+1] <= ctx_q[j];
    end
  end

  // Output register.
  logic signed [pwe_pkg::LevelWidth-1:0] lvl_d, lvl_q;
  logic signed [7:0] y;
  assign y = $signed({2'b00, quo_q[DS]});
  always_comb begin
    case (ctx_q[DS].cmd)
      pwe_pkg::CmdTriangle: lvl_d = pwe_pkg::LevelWidth'(ctx_q[DS].d_gt_p ?
                                   8'sd25 - y : y - 8'sd25);
      pwe_pkg::CmdSawtooth: lvl_d = pwe_pkg::LevelWidth'(y - 8'sd25);
      pwe_pkg::CmdPulse:    lvl_d = ctx_q[DS].pulse_hi ? 6'sd25 : -6'sd25;
      default:              lvl_d = '0;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (adv) lvl_q <= lvl_d;
  end

  assign out_if.valid = vld_q[NS-1];
  assign out_if.level = lvl_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.level))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.level <= 6'sd25 && out_if.level >= -6'sd25))
    else $error("level out of range");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipe moved while stalled");
endmodule

// ===== tb/tb_periodic_waveform_evaluator.sv =====
`timescale 1ns / 100ps

module tb_periodic_waveform_evaluator;

  localparam int unsigned TimeW = 32;
  // Pipeline depth, matching the valid stage count NS of the block.
  localparam int unsigned Latency = TimeW + 10;
  localparam int unsigned DrainCycles = 4 * Latency;
  localparam longint unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandomItems = 1400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pwe_pkg::PeriodWidth-1:0] cfg_wdata_i = '0;

  pwe_in_if #(.TimeWidth(TimeW)) in_if ();
  pwe_out_if out_if ();

  periodic_waveform_evaluator #(.TIME_WIDTH(TimeW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  // One row of directed stimulus; the level is typed in only where it is plain.
  typedef struct {
    pwe_pkg::cmd_e                         cmd;
    logic signed [TimeW-1:0]               t;
    logic [pwe_pkg::PwWidth-1:0]           pw;
    bit                                    has_level;
    logic signed [pwe_pkg::LevelWidth-1:0] level;
  } wave_row_t;

  // Shadow of the period register, as written.
  logic [pwe_pkg::PeriodWidth-1:0] period_shadow;
  logic signed [pwe_pkg::LevelWidth-1:0] level_queue[$];

  int unsigned  mismatches = 0;
  bit           failed = 1'b0;
  longint unsigned cycle_count = 0;

  // Idling control: the sender and receiver each idle about 21% of cycles.
  bit calm = 1'b0;        // long stretch with no idling
  bit hold_sink = 1'b0;   // request for one long receiver stall
  bit hold_done = 1'b0;
  int unsigned hold_cycles = 0;

  // Waveform level for one sample at the current period.
  function automatic logic signed [pwe_pkg::LevelWidth-1:0] wave_level(
    pwe_pkg::cmd_e cmd, logic signed [TimeW-1:0] t, logic [pwe_pkg::PwWidth-1:0] pw);
    longint unsigned p;
    longint unsigned ph;
    longint unsigned d;
    longint unsigned y;
    longint lhs;
    longint rhs;
    longint tv;
    int q;
    int lv;
    p = (period_shadow == 0) ? 1 : longint'(period_shadow);
    tv = longint'(t);
    // Negative times land on 1..P, so a phase of exactly P can occur.
    if (tv >= 0) ph = longint'(tv) % p;
    else ph = p - (longint'(-(tv + 1)) % p);
    case (cmd)
      pwe_pkg::CmdTriangle: begin
        d = ph * 2;
        y = ((d % p) * 50) / p;
        q = (d > p) ? int'(y) : 50 - int'(y);
        lv = 25 - q;
      end
      pwe_pkg::CmdSawtooth: lv = int'((ph * 50) / p) - 25;
      pwe_pkg::CmdPulse: begin
        lhs = longint'(ph) * 8190;
        rhs = longint'(p / 2) * 8190 + longint'(p) * (longint'(pw) * 2 - 4095);
        lv = (lhs > rhs) ? 25 : -25;
      end
      default: lv = 0;
    endcase
    return lv[pwe_pkg::LevelWidth-1:0];
  endfunction

  // Sender side.
  task automatic send_sample(pwe_pkg::cmd_e cmd, logic signed [TimeW-1:0] t,
                             logic [pwe_pkg::PwWidth-1:0] pw, bit has_level,
                             logic signed [pwe_pkg::LevelWidth-1:0] level);
    while (!calm && $urandom_range(99, 0) < 21) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.time_us     <= t;
    in_if.pulse_width <= pw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // Directed rows with a typed-in level must also agree with the predictor.
    if (has_level && level != wave_level(cmd, t, pw)) begin
      failed = 1'b1;
      $display("directed row: typed level %0d, predicted %0d", level,
               wave_level(cmd, t, pw));
    end
    level_queue.push_back(has_level ? level : wave_level(cmd, t, pw));
  endtask

  task automatic idle_sender();
    in_if.valid <= 1'b0;
  endtask

  // Wait until nothing is expected, then let the pipeline empty.
  task automatic drain();
    idle_sender();
    while (level_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_period(logic [pwe_pkg::PeriodWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    period_shadow = value;
    @(posedge clk_i);
  endtask

  function automatic logic signed [TimeW-1:0] random_time();
    logic signed [TimeW-1:0] t;
    case ($urandom_range(3, 0))
      0: t = $urandom();
      1: t = $signed($urandom_range(4000, 0)) - 2000;
      2: t = $signed(32'($urandom_range(3_000_000, 0)));
      default: t = -$signed(32'($urandom_range(3_000_000, 0)));
    endcase
    return t;
  endfunction

  function automatic logic [pwe_pkg::PwWidth-1:0] random_pw();
    case ($urandom_range(3, 0))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2048;
      default: return pwe_pkg::PwWidth'($urandom_range(4095, 0));
    endcase
  endfunction

  // Receiver side: random stalls, plus one long hold while the sender keeps going.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99, 0) >= 21);
    end
  end

  always @(posedge clk_i) begin
    if (hold_sink && !hold_done) begin
      hold_done   <= 1'b1;
      hold_cycles <= 300;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (level_queue.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected level %0d", out_if.level);
      end else begin
        if (out_if.level !== level_queue[0]) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("level mismatch: expected %0d, got %0d", level_queue[0],
                     out_if.level);
        end
        void'(level_queue.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_periodic_waveform_evaluator NOT OK");
      $finish;
    end
  end

  wave_row_t directed[] = '{
    // Reset period 1000: plain corner values.
    '{pwe_pkg::CmdSawtooth, 32'sd0,    12'd0,    1'b1, -6'sd25},
    '{pwe_pkg::CmdSawtooth, 32'sd999,  12'd0,    1'b1,  6'sd24},
    '{pwe_pkg::CmdTriangle, 32'sd0,    12'd0,    1'b1, -6'sd25},
    // Half period: 2*phase equals P, not above it, so the rising branch gives the bottom.
    '{pwe_pkg::CmdTriangle, 32'sd500,  12'd0,    1'b1, -6'sd25},
    // Zero width: phase 0 sits exactly on the threshold, so the level is low.
    '{pwe_pkg::CmdPulse,    32'sd0,    12'd0,    1'b1, -6'sd25},
    '{pwe_pkg::CmdPulse,    32'sd999,  12'd4095, 1'b1, -6'sd25},
    '{pwe_pkg::CmdNone,     32'sd1234, 12'd77,   1'b1,  6'sd0},
    // Negative times: -1 lands on phase P.
    '{pwe_pkg::CmdSawtooth, -32'sd1,   12'd0,    1'b1,  6'sd25},
    '{pwe_pkg::CmdTriangle, -32'sd1,   12'd0,    1'b0,  6'sd0},
    '{pwe_pkg::CmdPulse,    -32'sd1,   12'd2048, 1'b0,  6'sd0},
    '{pwe_pkg::CmdSawtooth, -32'sd1000, 12'd0,   1'b0,  6'sd0},
    // Time extremes.
    '{pwe_pkg::CmdTriangle, 32'h7FFF_FFFF, 12'd4095, 1'b0, 6'sd0},
    '{pwe_pkg::CmdSawtooth, 32'h8000_0000, 12'd0,    1'b0, 6'sd0},
    '{pwe_pkg::CmdPulse,    32'h8000_0000, 12'hAAA,  1'b0, 6'sd0},
    '{pwe_pkg::CmdPulse,    32'h7FFF_FFFF, 12'h555,  1'b0, 6'sd0},
    '{pwe_pkg::CmdPulse,    32'sd500,  12'd2048, 1'b0, 6'sd0},
    '{pwe_pkg::CmdPulse,    32'sd499,  12'd2047, 1'b0, 6'sd0},
    '{pwe_pkg::CmdNone,     32'h8000_0000, 12'hFFF,  1'b1, 6'sd0}
  };

  // Periods for the phases after the first, which keeps the reset value: extremes, zero and odd ones.
  logic [pwe_pkg::PeriodWidth-1:0] periods[] = '{20'd1, 20'd0, 20'hFFFFF,
                                                 20'd1000000, 20'd2, 20'd3,
                                                 20'd7, 20'd50, 20'd1001,
                                                 20'd65537};

  initial begin
    pwe_pkg::cmd_e cmd;
    int unsigned per_phase;

    in_if.valid       <= 1'b0;
    in_if.cmd         <= pwe_pkg::CmdTriangle;
    in_if.time_us     <= '0;
    in_if.pulse_width <= '0;
    period_shadow = pwe_pkg::PeriodReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset period.
    foreach (directed[i])
      send_sample(directed[i].cmd, directed[i].t, directed[i].pw,
                  directed[i].has_level, directed[i].level);
    drain();

    // Random phases across the period settings.
    per_phase = RandomItems / (periods.size() + 1);
    for (int ph = 0; ph <= periods.size(); ph++) begin
      if (ph != 0) write_period(periods[ph-1]);
      if (ph == 3) calm = 1'b1;
      if (ph == 4) calm = 1'b0;
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 5 && n == 10) hold_sink = 1'b1;
        // Sender pause until every expected level has come.
        if (ph == 6 && n == 50) begin
          idle_sender();
          while (level_queue.size() != 0) @(posedge clk_i);
        end
        cmd = pwe_pkg::cmd_e'($urandom_range(3, 0));
        send_sample(cmd, random_time(), random_pw(), 1'b0, '0);
      end
      drain();
    end

    if (!failed && mismatches == 0 && level_queue.size() == 0) begin
      $display("tb_periodic_waveform_evaluator OK");
    end else begin
      $display("tb_periodic_waveform_evaluator NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pwe_pkg.sv
rtl/core/pwe_if.sv
rtl/core/pwe_mod_cell.sv
rtl/core/pwe_div_cell.sv
rtl/core/periodic_waveform_evaluator.sv
tb/tb_periodic_waveform_evaluator.sv
